// ===== sv/cdct_pkg.sv =====
package cdct_pkg;

    // Default number of slots in the tag table.
    localparam int CACHE_SLOTS_DEF = 8;

    // Field widths fixed by the interface.
    localparam int ROW_W        = 16;
    localparam int SLOT_FIELD_W = 3;

    // The wrapped distance (L - r) + t spans -65535 .. 131070.
    localparam int DIST_W = ROW_W + 2;

    // Request kinds carried in tuser.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Controls from the sequencer to the slot evaluator.
    typedef struct packed {
        logic start;      // forget the previous scan
        logic sample;     // a tag read from the RAM is present this cycle
        logic tag_valid;  // valid bit of the slot being sampled
    } eval_ctrl_t;

    // Summary of a finished scan.
    typedef struct packed {
        logic hit_found;
        logic inv_found;
    } eval_stat_t;

endpackage

// ===== sv/cdct_tag_ram.sv =====
module cdct_tag_ram
    import cdct_pkg::*;
#(
    parameter int DEPTH  = CACHE_SLOTS_DEF,
    parameter int ADDR_W = $clog2(CACHE_SLOTS_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/cdct_slot_eval.sv =====
module cdct_slot_eval
    import cdct_pkg::*;
#(
    parameter int SLOT_W = $clog2(CACHE_SLOTS_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  eval_ctrl_t        ctrl,
    input  logic [SLOT_W-1:0] slot_idx,
    input  logic [ROW_W-1:0]  tag,
    input  logic [ROW_W-1:0]  row,
    input  logic [ROW_W-1:0]  list_length,
    output eval_stat_t        stat,
    output logic [SLOT_W-1:0] hit_slot,
    output logic [SLOT_W-1:0] victim_slot
);

    logic                     hit_found_reg, hit_found_next;
    logic [SLOT_W-1:0]        hit_slot_reg, hit_slot_next;
    logic                     inv_found_reg, inv_found_next;
    logic [SLOT_W-1:0]        inv_slot_reg, inv_slot_next;
    logic signed [DIST_W-1:0] best_reg, best_next;
    logic [SLOT_W-1:0]        best_slot_reg, best_slot_next;

    logic [ROW_W-1:0]         direct;
    logic signed [DIST_W-1:0] wrapped;
    logic signed [DIST_W-1:0] cyc_dist;

    // Cyclic distance of the sampled tag to the requested row.
    always_comb
    begin
        direct   = (tag >= row) ? (tag - row) : (row - tag);
        wrapped  = $signed({2'b00, list_length}) - $signed({2'b00, row})
                   + $signed({2'b00, tag});
        cyc_dist = ($signed({2'b00, direct}) < wrapped) ? $signed({2'b00, direct}) : wrapped;
    end

    always_comb
    begin
        hit_found_next = hit_found_reg;
        hit_slot_next  = hit_slot_reg;
        inv_found_next = inv_found_reg;
        inv_slot_next  = inv_slot_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        if (ctrl.start)
        begin
            hit_found_next = 1'b0;
            hit_slot_next  = '0;
            inv_found_next = 1'b0;
            inv_slot_next  = '0;
            best_next      = '0;
            best_slot_next = '0;
        end
        else if (ctrl.sample)
        begin
            if (ctrl.tag_valid)
            begin
                // Only the lowest matching slot counts as the hit.
                if (!hit_found_reg && tag == row)
                begin
                    hit_found_next = 1'b1;
                    hit_slot_next  = slot_idx;
                end
                if (cyc_dist > best_reg)
                begin
                    best_next      = cyc_dist;
                    best_slot_next = slot_idx;
                end
            end
            else if (!inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_slot_next  = slot_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg <= 1'b0;
            hit_slot_reg  <= '0;
            inv_found_reg <= 1'b0;
            inv_slot_reg  <= '0;
            best_reg      <= '0;
            best_slot_reg <= '0;
        end
        else
        begin
            hit_found_reg <= hit_found_next;
            hit_slot_reg  <= hit_slot_next;
            inv_found_reg <= inv_found_next;
            inv_slot_reg  <= inv_slot_next;
            best_reg      <= best_next;
            best_slot_reg <= best_slot_next;
        end
    end

    assign stat.hit_found = hit_found_reg;
    assign stat.inv_found = inv_found_reg;
    assign hit_slot       = hit_slot_reg;
    // An empty slot always wins over the distance choice.
    assign victim_slot    = inv_found_reg ? inv_slot_reg : best_slot_reg;

endmodule

// ===== sv/cyclic_distance_cache_tags_unit.sv =====
// Tag table of a small slot cache for a scrolling list. A request carries a
// kind in tuser (lookup or clear) and a list row in tdata. A lookup reports a
// hit with the lowest slot that already holds the row; on a miss it installs
// the row in the lowest empty slot or, with every slot in use, in the slot
// whose cyclic distance min(|tag - row|, (list_length - row) + tag) is
// strictly the largest, slot 0 being the default. A clear invalidates all
// slots and answers with a zero slot. The row tags live in a single-port-read
// synchronous RAM which is scanned one slot per cycle, so a lookup occupies
// the block through the scan, a drain state and a response state before the
// next acceptance, and a clear only through the response state. The valid
// bits are flip-flops cleared at once by reset or by a clear, so no clearing
// pass is needed. The result sits in an output register, and the block only
// stalls if that register is still full when the next result is ready.
// list_length should be written only while the block is idle.
module cyclic_distance_cache_tags_unit
    import cdct_pkg::*;
#(
    parameter int CACHE_SLOTS = CACHE_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    // Request stream.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [15:0] row_index
    input  logic [0:0]       s_axis_tuser,   // [0] opcode
    // Result stream.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [2:0] slot, [7:3] zero
    output logic [0:0]       m_axis_tuser,   // [0] hit
    // list_length register.
    input  logic             cfg_we,
    input  logic [ROW_W-1:0] cfg_wdata
);

    localparam int SLOT_W = $clog2(CACHE_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    state_t               state_reg;
    logic [ROW_W-1:0]     list_length_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 clear_reg;
    logic [SLOT_W-1:0]    idx_reg;
    logic                 rd_pend_reg;
    logic [SLOT_W-1:0]    rd_slot_reg;
    logic [CACHE_SLOTS-1:0] valid_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_hit_reg;

    logic                 in_acc;
    logic                 out_free;
    logic                 resp_load;
    logic                 ram_we;
    logic                 ram_re;
    logic [ROW_W-1:0]     ram_rdata;
    eval_ctrl_t           ev_ctrl;
    eval_stat_t           ev_stat;
    logic [SLOT_W-1:0]    hit_slot;
    logic [SLOT_W-1:0]    victim_slot;
    logic [SLOT_W-1:0]    result_slot;
    logic [SLOT_W+2:0]    slot_wide;
    logic                 result_hit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign resp_load     = (state_reg == ST_RESP) && out_free;
    assign ram_re        = (state_reg == ST_SCAN);
    // A miss installs the row; a hit or a clear leaves the tags alone.
    assign ram_we        = resp_load && !clear_reg && !ev_stat.hit_found;

    assign ev_ctrl.start     = in_acc;
    assign ev_ctrl.sample    = rd_pend_reg;
    assign ev_ctrl.tag_valid = valid_reg[rd_slot_reg];

    assign result_hit  = !clear_reg && ev_stat.hit_found;
    assign result_slot = clear_reg ? '0 : (ev_stat.hit_found ? hit_slot : victim_slot);
    // Slot numbers wider than the field are reported in their low bits.
    assign slot_wide   = {3'b000, result_slot};

    cdct_tag_ram #(
        .DEPTH  (CACHE_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (victim_slot),
        .wdata (row_reg),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    cdct_slot_eval #(
        .SLOT_W (SLOT_W)
    ) u_slot_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ev_ctrl),
        .slot_idx    (rd_slot_reg),
        .tag         (ram_rdata),
        .row         (row_reg),
        .list_length (list_length_reg),
        .stat        (ev_stat),
        .hit_slot    (hit_slot),
        .victim_slot (victim_slot)
    );

    // Sequencer: one RAM read per slot, a drain state in which the last read data
    // is evaluated, then the result and the install in the same cycle. Nothing
    // reads the RAM while a write is pending, so no forwarding is required.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            list_length_reg <= '0;
            row_reg         <= '0;
            clear_reg       <= 1'b0;
            idx_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            rd_slot_reg     <= '0;
            valid_reg       <= '0;
            m_valid_reg     <= 1'b0;
            m_data_reg      <= '0;
            m_hit_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                list_length_reg <= cfg_wdata;
            end

            // The output register is refilled in the same cycle as it drains.
            if (resp_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_pend_reg <= 1'b0;
                    if (in_acc)
                    begin
                        row_reg   <= s_axis_tdata;
                        idx_reg   <= '0;
                        clear_reg <= (s_axis_tuser[0] == OP_CLEAR);
                        if (s_axis_tuser[0] == OP_CLEAR)
                        begin
                            valid_reg <= '0;
                            state_reg <= ST_RESP;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    rd_pend_reg <= 1'b1;
                    rd_slot_reg <= idx_reg;
                    if (idx_reg == SLOT_W'(CACHE_SLOTS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    rd_pend_reg <= 1'b0;
                    state_reg   <= ST_RESP;
                end
                ST_RESP:
                begin
                    rd_pend_reg <= 1'b0;
                    if (resp_load)
                    begin
                        m_hit_reg   <= result_hit;
                        m_data_reg  <= {5'b00000, slot_wide[2:0]};
                        if (ram_we)
                        begin
                            valid_reg[victim_slot] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_hit_reg;

endmodule

// ===== sv/cdct_checker.sv =====
module cdct_checker
    import cdct_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [15:0]      s_axis_tdata,
    input logic [0:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [7:0]       m_axis_tdata,
    input logic [0:0]       m_axis_tuser,
    input logic             cfg_we
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // One request at a time: the block is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("request accepted while the previous one was still in progress");

    // A clear with the result register empty passes the response state and answers hit 0, slot 0.
    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser[0] == OP_CLEAR && !m_axis_tvalid)
        |=> ##1 (m_axis_tvalid && m_axis_tuser[0] == 1'b0 && m_axis_tdata == 8'h00))
        else $error("clear did not answer with a zero result in time");

    // A new result only appears at the end of the work on a request.
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared while the block was idle");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // list_length is only written while no request is in progress.
    a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> (s_axis_tready && !m_axis_tvalid))
        else $error("list_length written while a request was in progress");

endmodule

bind cyclic_distance_cache_tags_unit cdct_checker u_cdct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we)
);
